// ----- hw/rtl/gn2o_pkg.sv -----
// ---------------------------------------------------------------------------
// gn2o_pkg
// Shared types and constants for the 2D gradient noise octave unit.
// ---------------------------------------------------------------------------
package gn2o_pkg;

    // Request codes
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_RAW     = 2'd1;
    localparam logic [1:0] FUNC_FRACTAL = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_OCTAVES     = 2'd0;
    localparam logic [1:0] CFG_LACUNARITY  = 2'd1;
    localparam logic [1:0] CFG_PERSISTENCE = 2'd2;

    // Accumulator and divider widths
    localparam int TOTAL_W = 48;           // signed octave sum
    localparam int DEN_W   = 38;           // sum of amplitudes
    localparam int NUM_W   = TOTAL_W + 14; // |sum| << 14

    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    localparam logic [15:0] HALF_OFFSET = 16'd8192;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         table_index;
        logic [7:0]         table_value;
        logic signed [31:0] x_coord;
        logic signed [31:0] z_coord;
    } t_item;

    typedef struct packed {
        logic signed [15:0] noise_value;
        logic               saturated;
    } t_result;

endpackage

// ----- hw/rtl/gn2o_div.sv -----
// ---------------------------------------------------------------------------
// gn2o_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gn2o_div
    import gn2o_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic [NUM_W-1:0]   o_quot
);

    localparam int CW = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic             ge;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_cnt <= CW'(NUM_W - 1);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], ge};
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done longer than one cycle");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && !$past(i_start) && r_den != '0) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_run && !r_done))
        else $error("divider did not start");

endmodule

// ----- hw/rtl/gradient_noise_2d_octaves_unit.sv -----
// ---------------------------------------------------------------------------
// gradient_noise_2d_octaves_unit
// 2D gradient noise with fractal octave sum, fixed point, shared multiplier.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A table load
// (func 0) is written at that edge and busy stays low. A raw sample or a
// fractal request keeps busy high while it runs; a fractal request runs
// the noise steps once per octave (the last octave skips the frequency and
// amplitude update), then the final division and output step. The time is
// set by the single 33x33 multiplier, used once per cycle by the sequencer,
// and by the one bit per cycle divider. The result is shown on o_result with
// o_result_valid high for exactly one cycle, in the same cycle that busy falls;
// there is no backpressure, so it must be taken then.
module gradient_noise_2d_octaves_unit
    import gn2o_pkg::*;
#(
    parameter int TABLE_SIZE      = 256,
    parameter int MAX_OCTAVES     = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_result_valid,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int OW   = $clog2(MAX_OCTAVES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_PX, S_PZ, S_T2U, S_T3U, S_T4U, S_T5U, S_T2V, S_T3V, S_T4V,
        S_T5V, S_FADEV, S_BL2, S_BL3, S_BL4, S_SUM, S_ACC, S_ACCW, S_FRQ,
        S_AMP, S_AMPW, S_DIV, S_FIN
    } t_state;

    // Helpers
    function automatic logic [IDXW-1:0] fold8(input logic [7:0] b);
        logic [IDXW+7:0] w;
        w = {{IDXW{1'b0}}, b};
        return w[IDXW-1:0];
    endfunction

    function automatic logic [16:0] fade(input logic [16:0] t3,
                                         input logic [16:0] t4,
                                         input logic [16:0] t5);
        logic [24:0] acc;
        acc = (25'(t3) << 3) + (25'(t3) << 1) - ((25'(t4) << 4) - 25'(t4))
            + (25'(t5) << 2) + (25'(t5) << 1);
        if (acc[24])
            return 17'd0;
        else if (acc > 25'h1_0000)
            return 17'h1_0000;
        else
            return acc[16:0];
    endfunction

    // gradient dot product: bit 2 with bit 1 drops x, bit 2 alone drops z
    function automatic logic signed [19:0] dot(input logic [2:0] h,
                                               input logic signed [17:0] dx,
                                               input logic signed [17:0] dz);
        logic signed [19:0] gx;
        logic signed [19:0] gz;
        logic               nz;
        gx = (h[2] && h[1]) ? 20'sd0 : (h[0] ? -20'(dx) : 20'(dx));
        nz = h[2] ? h[0] : h[1];
        gz = (h[2] && !h[1]) ? 20'sd0 : (nz ? -20'(dz) : 20'(dz));
        return gx + gz;
    endfunction

    // Registers
    t_state                  r_state;
    logic [4:0]              r_octaves;
    logic [15:0]             r_lac;
    logic [15:0]             r_pers;
    t_item                   r_item;
    logic [7:0]              r_mem [TABLE_SIZE];
    logic [7:0]              r_rd;
    logic signed [65:0]      r_prod;
    logic [IDXW-1:0]         r_xi;
    logic [IDXW-1:0]         r_zi;
    logic [15:0]             r_xf;
    logic [15:0]             r_zf;
    logic [16:0]             r_t3;
    logic [16:0]             r_t4;
    logic [16:0]             r_u;
    logic [16:0]             r_v;
    logic [7:0]              r_ha;
    logic [7:0]              r_hb;
    logic [7:0]              r_aa;
    logic [7:0]              r_ab;
    logic [7:0]              r_ba;
    logic [7:0]              r_bb;
    logic signed [19:0]      r_r1;
    logic signed [19:0]      r_r2;
    logic signed [19:0]      r_s;
    logic [31:0]             r_freq;
    logic [31:0]             r_amp;
    logic signed [TOTAL_W-1:0] r_total;
    logic [DEN_W-1:0]        r_amp_sum;
    logic [OW-1:0]           r_left;
    logic                    r_sat;
    logic                    r_div_start;
    logic                    r_valid;
    t_result                 r_out;

    // Next values and datapath
    logic signed [32:0]      n_mul_a;
    logic signed [32:0]      n_mul_b;
    logic [IDXW-1:0]         n_rd_addr;
    logic [OW-1:0]           n_count;
    logic                    accept;
    logic [16:0]             t_hi;
    logic signed [20:0]      blend_term;
    logic signed [17:0]      dx0, dx1, dz0, dz1;
    logic signed [19:0]      d_aa, d_ab, d_ba, d_bb;
    logic signed [20:0]      n_r1, n_r2, n_s;
    logic signed [17:0]      raw_q;
    logic [TOTAL_W-1:0]      mag;
    logic                    div_done;
    logic [NUM_W-1:0]        quot;
    logic signed [NUM_W+1:0] n_final;
    logic [31:0]             n_freq;
    logic [31:0]             n_amp;
    logic                    freq_sat;
    logic                    amp_sat;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Effective octave count
    always_comb begin
        if (r_octaves == 5'd0)
            n_count = OW'(1);
        else if ({1'b0, r_octaves} > 6'(MAX_OCTAVES))
            n_count = OW'(MAX_OCTAVES);
        else
            n_count = OW'(r_octaves);
    end

    // Gradient offsets and corner dots
    assign dx0  = {2'b00, r_xf};
    assign dx1  = {2'b11, r_xf};
    assign dz0  = {2'b00, r_zf};
    assign dz1  = {2'b11, r_zf};
    assign d_aa = dot(r_aa[2:0], dx0, dz0);
    assign d_ba = dot(r_ba[2:0], dx1, dz0);
    assign d_ab = dot(r_ab[2:0], dx0, dz1);
    assign d_bb = dot(r_bb[2:0], dx1, dz1);

    assign t_hi       = r_prod[32:16];
    assign blend_term = r_prod[36:16];
    assign n_r1       = 21'(d_aa) + blend_term;
    assign n_r2       = 21'(d_ab) + blend_term;
    assign n_s        = 21'(r_r1) + blend_term;
    assign raw_q      = 18'(n_s >>> 2);

    // Frequency and amplitude updates, saturating at 32 bits
    assign freq_sat = (r_prod[65:40] != '0);
    assign n_freq   = freq_sat ? '1 : r_prod[39:8];
    assign amp_sat  = freq_sat;
    assign n_amp    = n_freq;

    // Shared multiplier operand select
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        case (r_state)
            S_PX: begin
                n_mul_a = 33'(r_item.x_coord);
                n_mul_b = {1'b0, r_freq};
            end
            S_PZ: begin
                n_mul_a = 33'(r_item.z_coord);
                n_mul_b = {1'b0, r_freq};
            end
            S_T2U: begin
                n_mul_a = {17'd0, r_xf};
                n_mul_b = {17'd0, r_xf};
            end
            S_T3U, S_T4U, S_T5U: begin
                n_mul_a = {16'd0, t_hi};
                n_mul_b = {17'd0, r_xf};
            end
            S_T2V: begin
                n_mul_a = {17'd0, r_zf};
                n_mul_b = {17'd0, r_zf};
            end
            S_T3V, S_T4V, S_T5V: begin
                n_mul_a = {16'd0, t_hi};
                n_mul_b = {17'd0, r_zf};
            end
            S_FADEV: begin
                n_mul_a = 33'(d_ba) - 33'(d_aa);
                n_mul_b = {16'd0, r_u};
            end
            S_BL2: begin
                n_mul_a = 33'(d_bb) - 33'(d_ab);
                n_mul_b = {16'd0, r_u};
            end
            S_BL4: begin
                n_mul_a = 33'(r_r2) - 33'(r_r1);
                n_mul_b = {16'd0, r_v};
            end
            S_ACC: begin
                n_mul_a = 33'(r_s);
                n_mul_b = {1'b0, r_amp};
            end
            S_FRQ: begin
                n_mul_a = {1'b0, r_freq};
                n_mul_b = {17'd0, r_lac};
            end
            S_AMP: begin
                n_mul_a = {1'b0, r_amp};
                n_mul_b = {17'd0, r_pers};
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    // Table read address per step
    always_comb begin
        case (r_state)
            S_T2U:   n_rd_addr = r_xi;
            S_T3U:   n_rd_addr = r_xi + 1'b1;
            S_T4U:   n_rd_addr = fold8(r_ha) + r_zi;
            S_T5U:   n_rd_addr = fold8(r_ha) + r_zi + 1'b1;
            S_T2V:   n_rd_addr = fold8(r_hb) + r_zi;
            S_T3V:   n_rd_addr = fold8(r_hb) + r_zi + 1'b1;
            default: n_rd_addr = '0;
        endcase
    end

    // Permutation table
    always_ff @(posedge i_clk) begin
        if (accept && i_item.func == FUNC_LOAD)
            r_mem[fold8(i_item.table_index)] <= i_item.table_value;
        r_rd <= r_mem[n_rd_addr];
    end

    // Final divide
    assign mag = r_total[TOTAL_W-1] ? TOTAL_W'(-r_total) : TOTAL_W'(r_total);

    gn2o_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   ({mag, 14'd0}),
        .i_den   (r_amp_sum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // signed quotient, halved (floor), plus one half
    always_comb begin
        logic signed [NUM_W+1:0] q_s;
        q_s = {2'b00, quot};
        if (r_total[TOTAL_W-1])
            q_s = -q_s;
        n_final = (q_s >>> 1) + $signed((NUM_W+2)'(HALF_OFFSET));
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_octaves   <= 5'd4;
            r_lac       <= 16'd512;
            r_pers      <= 16'd128;
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_prod      <= n_mul_a * n_mul_b;
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OCTAVES:     r_octaves <= i_cfg_wdata[4:0];
                    CFG_LACUNARITY:  r_lac     <= i_cfg_wdata;
                    CFG_PERSISTENCE: r_pers    <= i_cfg_wdata;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept && (i_item.func == FUNC_RAW ||
                                   i_item.func == FUNC_FRACTAL)) begin
                        r_item    <= i_item;
                        r_freq    <= ONE_Q16;
                        r_amp     <= ONE_Q16;
                        r_total   <= '0;
                        r_amp_sum <= '0;
                        r_sat     <= 1'b0;
                        r_left    <= (i_item.func == FUNC_RAW) ? '0 : n_count - 1'b1;
                        r_state   <= S_PX;
                    end
                end
                S_PX:  r_state <= S_PZ;
                S_PZ: begin
                    r_xi    <= r_prod[COORD_FRAC_BITS+16 +: IDXW];
                    r_xf    <= r_prod[COORD_FRAC_BITS +: 16];
                    r_state <= S_T2U;
                end
                S_T2U: begin
                    r_zi    <= r_prod[COORD_FRAC_BITS+16 +: IDXW];
                    r_zf    <= r_prod[COORD_FRAC_BITS +: 16];
                    r_state <= S_T3U;
                end
                S_T3U: begin
                    r_ha    <= r_rd;
                    r_state <= S_T4U;
                end
                S_T4U: begin
                    r_hb    <= r_rd;
                    r_t3    <= t_hi;
                    r_state <= S_T5U;
                end
                S_T5U: begin
                    r_aa    <= r_rd;
                    r_t4    <= t_hi;
                    r_state <= S_T2V;
                end
                S_T2V: begin
                    r_ab    <= r_rd;
                    r_u     <= fade(r_t3, r_t4, t_hi);
                    r_state <= S_T3V;
                end
                S_T3V: begin
                    r_ba    <= r_rd;
                    r_state <= S_T4V;
                end
                S_T4V: begin
                    r_bb    <= r_rd;
                    r_t3    <= t_hi;
                    r_state <= S_T5V;
                end
                S_T5V: begin
                    r_t4    <= t_hi;
                    r_state <= S_FADEV;
                end
                S_FADEV: begin
                    r_v     <= fade(r_t3, r_t4, t_hi);
                    r_state <= S_BL2;
                end
                S_BL2: begin
                    r_r1    <= 20'(n_r1);
                    r_state <= S_BL3;
                end
                S_BL3: begin
                    r_r2    <= 20'(n_r2);
                    r_state <= S_BL4;
                end
                S_BL4: r_state <= S_SUM;
                S_SUM: begin
                    if (r_item.func == FUNC_RAW) begin
                        r_valid <= 1'b1;
                        if (raw_q > 18'sd32767) begin
                            r_out <= '{noise_value: 16'sh7FFF, saturated: 1'b1};
                        end else if (raw_q < -18'sd32768) begin
                            r_out <= '{noise_value: 16'sh8000, saturated: 1'b1};
                        end else begin
                            r_out <= '{noise_value: 16'(raw_q), saturated: r_sat};
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_s     <= 20'(n_s);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: r_state <= S_ACCW;
                S_ACCW: begin
                    r_total   <= r_total + r_prod[TOTAL_W+15:16];
                    r_amp_sum <= r_amp_sum + DEN_W'(r_amp);
                    if (r_left == '0) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end else begin
                        r_left  <= r_left - 1'b1;
                        r_state <= S_FRQ;
                    end
                end
                S_FRQ: r_state <= S_AMP;
                S_AMP: begin
                    r_freq  <= n_freq;
                    r_sat   <= r_sat | freq_sat;
                    r_state <= S_AMPW;
                end
                S_AMPW: begin
                    r_amp   <= n_amp;
                    r_sat   <= r_sat | amp_sat;
                    r_state <= S_PX;
                end
                S_DIV: begin
                    if (div_done)
                        r_state <= S_FIN;
                end
                S_FIN: begin
                    r_valid <= 1'b1;
                    if (n_final > (NUM_W+2)'(32767)) begin
                        r_out <= '{noise_value: 16'sh7FFF, saturated: 1'b1};
                    end else if (n_final < -(NUM_W+2)'(32768)) begin
                        r_out <= '{noise_value: 16'sh8000, saturated: 1'b1};
                    end else begin
                        r_out <= '{noise_value: 16'(n_final), saturated: r_sat};
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_out;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.func == FUNC_RAW || i_item.func == FUNC_FRACTAL))
        |=> (busy && !o_result_valid))
        else $error("sample request not started");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.func == FUNC_LOAD || i_item.func == FUNC_NONE))
        |=> (!busy && !o_result_valid))
        else $error("table load or unused code produced work");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

endmodule
